[rtl/rtccal_pkg.sv]
`timescale 1ns / 1ps

package rtccal_pkg;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_HOUR = 2'd1,
    MODE_LOAD = 2'd2
  } mode_e;

  localparam logic [6:0] YEAR_LAST   = 7'd99;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [5:0] SEC_LAST    = 6'd59;
  localparam logic [2:0] WD_SUNDAY   = 3'd7;
  localparam logic [2:0] WD_RESET    = 3'd6;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [2:0] SAK_OFF [12] = '{
    3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
  };

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_sec;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_day;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [5:0] cur_sec;
    logic [2:0] cur_weekday;
    logic       load_rejected;
  } out_item_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] sec;
    logic [2:0] weekday;
  } cal_t;

  // Within 2000 to 2099 a year is a leap year exactly when it is a multiple of four.
  function automatic logic [4:0] days_in(input logic [6:0] year, input logic [3:0] month);
    logic [4:0] len;
    len = 5'd0;
    if (month >= 4'd1 && month <= MONTH_LAST) begin
      len = MONTH_LEN[month - 4'd1];
      if (month == 4'd2 && year[1:0] == 2'b00) begin
        len = 5'd29;
      end
    end
    return len;
  endfunction

  // Sakamoto's method reduced to the two-digit year: the century terms fold into a
  // constant that is a multiple of seven, and 1999 gives a base of five.
  function automatic logic [2:0] weekday_of(input logic [6:0] year, input logic [3:0] month,
                                            input logic [4:0] day);
    logic       early;
    logic [6:0] k;
    logic [7:0] base;
    logic [7:0] sum;
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] r;
    early = (month == 4'd1) || (month == 4'd2);
    k     = year - {6'd0, early};
    if (early && year == 7'd0) begin
      base = 8'd5;
    end else begin
      base = {1'b0, k} + {3'd0, k[6:2]};
    end
    sum = base + {5'd0, SAK_OFF[month - 4'd1]} + {3'd0, day};
    s1  = {1'b0, sum[7:3]} + {3'd0, sum[2:0]};
    s2  = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) begin
      r = 3'(s2 - 4'd7);
    end else begin
      r = s2[2:0];
    end
    return (r == 3'd0) ? WD_SUNDAY : r;
  endfunction

endpackage

[rtl/rtccal_if.sv]
`timescale 1ns / 1ps

interface rtccal_in_if;
  import rtccal_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtccal_out_if;
  import rtccal_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rtccal_in_stage.sv]
`timescale 1ns / 1ps

module rtccal_in_stage import rtccal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtccal_in_if.sink  in_i,
  input  logic       advance_i,
  output logic       valid_o,
  output in_item_t   item_o
);

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_i.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/rtccal_step.sv]
`timescale 1ns / 1ps

module rtccal_step import rtccal_pkg::*; (
  input  cal_t     cal_i,
  input  in_item_t item_i,
  output cal_t     cal_o,
  output logic     rejected_o
);

  logic load_ok;
  logic min_inc;
  logic hour_inc;
  logic day_inc;
  logic month_inc;
  cal_t nxt;

  always_comb begin
    load_ok = item_i.load_year <= YEAR_LAST
           && item_i.load_month inside {[4'd1:MONTH_LAST]}
           && item_i.load_day >= 5'd1
           && item_i.load_day <= days_in(item_i.load_year, item_i.load_month)
           && item_i.load_hour <= HOUR_LAST
           && item_i.load_minute <= MINUTE_LAST
           && item_i.load_sec <= SEC_LAST;
  end

  always_comb begin
    nxt        = cal_i;
    rejected_o = 1'b0;
    min_inc    = 1'b0;
    hour_inc   = 1'b0;
    day_inc    = 1'b0;
    month_inc  = 1'b0;
    case (item_i.mode)
      MODE_TICK: begin
        if (cal_i.sec == SEC_LAST) begin
          nxt.sec = 6'd0;
          min_inc = 1'b1;
        end else begin
          nxt.sec = cal_i.sec + 6'd1;
        end
      end
      MODE_HOUR: begin
        hour_inc = 1'b1;
      end
      MODE_LOAD: begin
        if (load_ok) begin
          nxt.year    = item_i.load_year;
          nxt.month   = item_i.load_month;
          nxt.day     = item_i.load_day;
          nxt.hour    = item_i.load_hour;
          nxt.minute  = item_i.load_minute;
          nxt.sec     = item_i.load_sec;
          nxt.weekday = weekday_of(item_i.load_year, item_i.load_month, item_i.load_day);
        end else begin
          rejected_o = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (min_inc) begin
      if (cal_i.minute == MINUTE_LAST) begin
        nxt.minute = 6'd0;
        hour_inc   = 1'b1;
      end else begin
        nxt.minute = cal_i.minute + 6'd1;
      end
    end

    if (hour_inc) begin
      if (cal_i.hour == HOUR_LAST) begin
        nxt.hour = 5'd0;
        day_inc  = 1'b1;
      end else begin
        nxt.hour = cal_i.hour + 5'd1;
      end
    end

    if (day_inc) begin
      nxt.weekday = (cal_i.weekday == WD_SUNDAY) ? 3'd1 : cal_i.weekday + 3'd1;
      if (cal_i.day >= days_in(cal_i.year, cal_i.month)) begin
        nxt.day   = 5'd1;
        month_inc = 1'b1;
      end else begin
        nxt.day = cal_i.day + 5'd1;
      end
    end

    if (month_inc) begin
      if (cal_i.month == MONTH_LAST) begin
        nxt.month = 4'd1;
        nxt.year  = (cal_i.year == YEAR_LAST) ? 7'd0 : cal_i.year + 7'd1;
      end else begin
        nxt.month = cal_i.month + 4'd1;
      end
    end
  end

  assign cal_o = nxt;

endmodule

[rtl/rtc_calendar_counter.sv]
`timescale 1ns / 1ps

// Calendar counter for the years 2000 to 2099, reset to Saturday 2000-01-01 00:00:00.
// Each item ticks one second, adds one hour or loads a checked date and time (any
// other mode leaves the time as it is), and returns one result with the time after
// that step. An item is registered on acceptance and its result appears in the output
// register at the next clock edge at which that register is free; one item is taken
// in every cycle while the output is not held back, as the whole calendar update is a
// single pass of logic between the input register and the state and result registers.

module rtc_calendar_counter import rtccal_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rtccal_in_if.sink    in_i,
  rtccal_out_if.source out_o
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      advance;
  cal_t      cal_q;
  cal_t      cal_d;
  logic      rejected;
  logic      out_valid_q;
  out_item_t res_q;

  assign advance = stage_valid && (!out_valid_q || out_o.ready);

  rtccal_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  rtccal_step u_step (
    .cal_i      (cal_q),
    .item_i     (stage_item),
    .cal_o      (cal_d),
    .rejected_o (rejected)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q       <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
                       minute: 6'd0, sec: 6'd0, weekday: WD_RESET};
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        cal_q <= cal_d;
      end
      out_valid_q <= advance || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= '{cur_year: cal_d.year, cur_month: cal_d.month, cur_day: cal_d.day,
                 cur_hour: cal_d.hour, cur_minute: cal_d.minute, cur_sec: cal_d.sec,
                 cur_weekday: cal_d.weekday, load_rejected: rejected};
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  a_state_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q.weekday != 3'd0 && cal_q.month != 4'd0 && cal_q.month <= MONTH_LAST
      && cal_q.day != 5'd0 && cal_q.hour <= HOUR_LAST)
    else $error("calendar state out of range");

  a_tick_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stage_item.mode == MODE_TICK |=> out_o.valid && !out_o.data.load_rejected)
    else $error("tick item flagged as rejected load");

  a_tick_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stage_item.mode == MODE_TICK && cal_q.sec != SEC_LAST
      |=> cal_q.sec == $past(cal_q.sec) + 6'd1 && $stable(cal_q.minute))
    else $error("tick did not advance the second alone");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rejected |=> $stable(cal_q))
    else $error("rejected load changed the time");

endmodule
